FILE: hw/rtl/stbp_pkg.sv
package stbp_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int SIZE_BITS_DEF  = 16;

    localparam int CMD_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int TIME_W     = 32;
    localparam int PCNT_W     = 32;
    localparam int TOTAL_W    = 48;
    localparam int OUT_SIZE_W = 16;
    localparam int TOPC_W     = 32;
    localparam int HIST_DEPTH = 1 << BYTE_W;

    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BOUND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic              en;
        logic              clr;
        logic [BYTE_W-1:0] addr;
    } t_hist_wr;

    typedef struct packed {
        logic              chk;
        logic [TIME_W-1:0] gap;
        logic [PCNT_W-1:0] nm1;
        logic [TIME_W-1:0] span;
    } t_burst_req;

endpackage

FILE: hw/rtl/stbp_hist.sv
module stbp_hist
    import stbp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [BYTE_W-1:0]     i_rd_addr,
    input  t_hist_wr              i_wr,
    input  logic [COUNT_BITS-1:0] i_wr_data,
    output logic [COUNT_BITS-1:0] o_count
);

    logic [COUNT_BITS-1:0] mem [HIST_DEPTH];
    logic [COUNT_BITS-1:0] r_rd_data;
    logic [COUNT_BITS-1:0] r_fwd_data;
    logic [HIST_DEPTH-1:0] r_vld;
    logic                  r_rd_vld;
    logic                  r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wr.clr) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_vld  <= r_vld[i_rd_addr] && !i_wr.clr;
            r_fwd_hit <= i_wr.en && (i_wr.addr == i_rd_addr);
        end
    end

    assign o_count = r_fwd_hit ? r_fwd_data : (r_rd_vld ? r_rd_data : '0);

endmodule

FILE: hw/rtl/stbp_burst.sv
module stbp_burst
    import stbp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_burst_req i_req,
    output logic       o_hit
);

    logic [2*TIME_W-1:0] prod;
    logic [2*TIME_W-1:0] r_lhs;
    logic [TIME_W-1:0]   r_span;
    logic                r_chk;

    assign prod = i_req.gap * i_req.nm1;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lhs  <= prod;
            r_span <= i_req.span;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk <= 1'b0;
        end else if (i_load) begin
            r_chk <= i_req.chk;
        end
    end

    assign o_hit = r_chk && (r_span != '0)
                 && ({r_lhs, 1'b0} < {{(TIME_W+1){1'b0}}, r_span});

endmodule

FILE: hw/rtl/serial_traffic_burst_profiler_top.sv
// Channel | Handshake                   | Payload
// input   | i_in_valid / o_in_stall     | i_command, i_data_byte, i_time_ms
// output  | o_out_valid / i_out_stall   | o_packet_recorded .. o_top_count
//
// One transfer per cycle sustained while the output is not stalled; each accepted transfer
// passes through execute (histogram write-back and burst multiply), burst compare, output.
// The histogram memory read-modify-write with forwarding sets the rate.
// Reset and the clear command zero the profile at once through per-entry valid bits.
// A stalled output holds its result; empty stages upstream keep filling.
module serial_traffic_burst_profiler_top
    import stbp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [BYTE_W-1:0]     i_data_byte,
    input  logic [TIME_W-1:0]     i_time_ms,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_packet_recorded,
    output logic                  o_is_burst,
    output logic [OUT_SIZE_W-1:0] o_packet_size,
    output logic [PCNT_W-1:0]     o_packet_count,
    output logic [PCNT_W-1:0]     o_burst_count,
    output logic [TOTAL_W-1:0]    o_total_bytes,
    output logic [BYTE_W-1:0]     o_top_byte,
    output logic [TOPC_W-1:0]     o_top_count
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX     = '1;
    localparam logic [SIZE_BITS-1:0]  SIZE_MAX    = '1;
    localparam logic [PCNT_W-1:0]     PCNT_MAX    = '1;
    localparam logic [PCNT_W-1:0]     PCNT_MAX_M1 = {{(PCNT_W-1){1'b1}}, 1'b0};
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX   = '1;

    logic s3_free, s2_go, s2_free, s1_go, s1_free, in_acc;

    logic                  r_s1_v;
    logic [CMD_W-1:0]      r_s1_cmd;
    logic [BYTE_W-1:0]     r_s1_byte;
    logic [TIME_W-1:0]     r_s1_time;

    logic [SIZE_BITS-1:0]  r_open,   n_open;
    logic [PCNT_W-1:0]     r_pcnt,   n_pcnt;
    logic [TIME_W-1:0]     r_first,  n_first;
    logic [TIME_W-1:0]     r_prev,   n_prev;
    logic [TOTAL_W-1:0]    r_total,  n_total;
    logic [BYTE_W-1:0]     r_lead_b, n_lead_b;
    logic [COUNT_BITS-1:0] r_lead_c, n_lead_c;
    logic [PCNT_W-1:0]     r_bcnt,   n_bcnt;

    logic [COUNT_BITS-1:0] cur, inc;
    logic                  hist_we, hist_clr, s1_rec;
    logic [SIZE_BITS-1:0]  s1_size;
    t_burst_req            breq;
    t_hist_wr              hwr;
    logic                  burst_hit, s2_burst;

    logic [SIZE_BITS+OUT_SIZE_W-1:0] size_ext;
    logic [COUNT_BITS+TOPC_W-1:0]    topc_ext;

    logic                  r_s2_v;
    logic                  r_s2_rec;
    logic                  r_s2_clr;
    logic [OUT_SIZE_W-1:0] r_s2_size;
    logic [PCNT_W-1:0]     r_s2_pcnt;
    logic [TOTAL_W-1:0]    r_s2_total;
    logic [BYTE_W-1:0]     r_s2_top_b;
    logic [TOPC_W-1:0]     r_s2_top_c;

    logic                  r_o_valid;
    logic                  r_o_rec;
    logic                  r_o_burst;
    logic [OUT_SIZE_W-1:0] r_o_size;
    logic [PCNT_W-1:0]     r_o_pcnt;
    logic [PCNT_W-1:0]     r_o_bcnt;
    logic [TOTAL_W-1:0]    r_o_total;
    logic [BYTE_W-1:0]     r_o_top_b;
    logic [TOPC_W-1:0]     r_o_top_c;

    assign s3_free    = !r_o_valid || !i_out_stall;
    assign s2_go      = r_s2_v && s3_free;
    assign s2_free    = !r_s2_v || s3_free;
    assign s1_go      = r_s1_v && s2_free;
    assign s1_free    = !r_s1_v || s2_free;
    assign o_in_stall = !s1_free;
    assign in_acc     = i_in_valid && s1_free;

    assign hwr = '{en: hist_we && s1_go, clr: hist_clr && s1_go, addr: r_s1_byte};

    stbp_hist #(
        .COUNT_BITS(COUNT_BITS)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (i_data_byte),
        .i_wr      (hwr),
        .i_wr_data (inc),
        .o_count   (cur)
    );

    stbp_burst u_burst (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_go),
        .i_req   (breq),
        .o_hit   (burst_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_free) begin
            r_s1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd  <= i_command;
            r_s1_byte <= i_data_byte;
            r_s1_time <= i_time_ms;
        end
    end

    always_comb begin
        n_open   = r_open;
        n_pcnt   = r_pcnt;
        n_first  = r_first;
        n_prev   = r_prev;
        n_total  = r_total;
        n_lead_b = r_lead_b;
        n_lead_c = r_lead_c;
        hist_we  = 1'b0;
        hist_clr = 1'b0;
        s1_rec   = 1'b0;
        s1_size  = '0;
        breq     = '0;
        inc      = (cur == CNT_MAX) ? cur : cur + 1'b1;
        case (r_s1_cmd)
            CMD_DATA: begin
                hist_we = 1'b1;
                if (r_open != SIZE_MAX) begin
                    n_open = r_open + 1'b1;
                end
                if (r_total != TOTAL_MAX) begin
                    n_total = r_total + 1'b1;
                end
                if (inc > r_lead_c || (inc == r_lead_c && r_s1_byte < r_lead_b)) begin
                    n_lead_c = inc;
                    n_lead_b = r_s1_byte;
                end
            end
            CMD_BOUND: begin
                if (r_open != '0) begin
                    s1_rec    = 1'b1;
                    s1_size   = r_open;
                    n_open    = '0;
                    n_prev    = r_s1_time;
                    n_pcnt    = (r_pcnt == PCNT_MAX) ? r_pcnt : r_pcnt + 1'b1;
                    breq.chk  = (r_pcnt != '0);
                    breq.gap  = r_s1_time - r_prev;
                    breq.span = r_s1_time - r_first;
                    breq.nm1  = (r_pcnt == PCNT_MAX) ? PCNT_MAX_M1 : r_pcnt;
                    if (r_pcnt == '0) begin
                        n_first = r_s1_time;
                    end
                end
            end
            CMD_CLEAR: begin
                hist_clr = 1'b1;
                n_open   = '0;
                n_pcnt   = '0;
                n_first  = '0;
                n_prev   = '0;
                n_total  = '0;
                n_lead_b = '0;
                n_lead_c = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open   <= '0;
            r_pcnt   <= '0;
            r_first  <= '0;
            r_prev   <= '0;
            r_total  <= '0;
            r_lead_b <= '0;
            r_lead_c <= '0;
        end else if (s1_go) begin
            r_open   <= n_open;
            r_pcnt   <= n_pcnt;
            r_first  <= n_first;
            r_prev   <= n_prev;
            r_total  <= n_total;
            r_lead_b <= n_lead_b;
            r_lead_c <= n_lead_c;
        end
    end

    assign size_ext = {{OUT_SIZE_W{1'b0}}, s1_size};
    assign topc_ext = {{TOPC_W{1'b0}}, n_lead_c};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_free) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2_rec   <= s1_rec;
            r_s2_clr   <= hist_clr;
            r_s2_size  <= size_ext[OUT_SIZE_W-1:0];
            r_s2_pcnt  <= n_pcnt;
            r_s2_total <= n_total;
            r_s2_top_b <= n_lead_b;
            r_s2_top_c <= topc_ext[TOPC_W-1:0];
        end
    end

    assign s2_burst = r_s2_rec && burst_hit;

    always_comb begin
        n_bcnt = r_bcnt;
        if (r_s2_clr) begin
            n_bcnt = '0;
        end else if (s2_burst && r_bcnt != PCNT_MAX) begin
            n_bcnt = r_bcnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (s2_go) begin
                r_bcnt <= n_bcnt;
            end
            if (s3_free) begin
                r_o_valid <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_o_rec   <= r_s2_rec;
            r_o_burst <= s2_burst;
            r_o_size  <= r_s2_size;
            r_o_pcnt  <= r_s2_pcnt;
            r_o_bcnt  <= n_bcnt;
            r_o_total <= r_s2_total;
            r_o_top_b <= r_s2_top_b;
            r_o_top_c <= r_s2_top_c;
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_packet_recorded = r_o_rec;
    assign o_is_burst        = r_o_burst;
    assign o_packet_size     = r_o_size;
    assign o_packet_count    = r_o_pcnt;
    assign o_burst_count     = r_o_bcnt;
    assign o_total_bytes     = r_o_total;
    assign o_top_byte        = r_o_top_b;
    assign o_top_count       = r_o_top_c;

endmodule

FILE: hw/rtl/stbp_chk.sv
module stbp_chk
    import stbp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic                  o_packet_recorded,
    input logic                  o_is_burst,
    input logic [OUT_SIZE_W-1:0] o_packet_size,
    input logic [PCNT_W-1:0]     o_packet_count,
    input logic [PCNT_W-1:0]     o_burst_count,
    input logic [TOTAL_W-1:0]    o_total_bytes
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_packet_count)
            && $stable(o_burst_count) && $stable(o_total_bytes))
        else $error("stalled result changed");

    a_no_packet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_packet_recorded |-> !o_is_burst && o_packet_size == '0)
        else $error("packet fields set without a recorded packet");

    a_recorded_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_recorded |-> o_packet_count != '0 && o_packet_size != '0)
        else $error("recorded packet not counted");

    a_burst_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_burst |-> o_burst_count != '0 && o_packet_count != '0)
        else $error("burst flagged but not counted");

endmodule

bind serial_traffic_burst_profiler_top stbp_chk u_stbp_chk (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import stbp_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int ITEM_BUDGET    = 1030;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [COUNT_BITS_DEF-1:0] HIST_MAX  = {COUNT_BITS_DEF{1'b1}};
    localparam logic [SIZE_BITS_DEF-1:0]  LEN_MAX   = {SIZE_BITS_DEF{1'b1}};
    localparam logic [PCNT_W-1:0]         PCNT_MAX  = {PCNT_W{1'b1}};
    localparam logic [TOTAL_W-1:0]        TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic                  recorded;
        logic                  burst;
        logic [OUT_SIZE_W-1:0] size;
        logic [PCNT_W-1:0]     pkt_count;
        logic [PCNT_W-1:0]     burst_count;
        logic [TOTAL_W-1:0]    total;
        logic [BYTE_W-1:0]     top_val;
        logic [TOPC_W-1:0]     top_hits;
    } t_profile_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [CMD_W-1:0]      i_command = CMD_DATA;
    logic [BYTE_W-1:0]     i_data_byte = '0;
    logic [TIME_W-1:0]     i_time_ms = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_packet_recorded;
    logic                  o_is_burst;
    logic [OUT_SIZE_W-1:0] o_packet_size;
    logic [PCNT_W-1:0]     o_packet_count;
    logic [PCNT_W-1:0]     o_burst_count;
    logic [TOTAL_W-1:0]    o_total_bytes;
    logic [BYTE_W-1:0]     o_top_byte;
    logic [TOPC_W-1:0]     o_top_count;

    serial_traffic_burst_profiler_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_data_byte       (i_data_byte),
        .i_time_ms         (i_time_ms),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_packet_recorded (o_packet_recorded),
        .o_is_burst        (o_is_burst),
        .o_packet_size     (o_packet_size),
        .o_packet_count    (o_packet_count),
        .o_burst_count     (o_burst_count),
        .o_total_bytes     (o_total_bytes),
        .o_top_byte        (o_top_byte),
        .o_top_count       (o_top_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [COUNT_BITS_DEF-1:0] byte_tally [HIST_DEPTH];
    logic [SIZE_BITS_DEF-1:0]  open_len;
    logic [PCNT_W-1:0]         pkt_total;
    logic [PCNT_W-1:0]         burst_total;
    logic [TIME_W-1:0]         first_ms;
    logic [TIME_W-1:0]         last_ms;
    logic [TOTAL_W-1:0]        byte_total;
    logic [BYTE_W-1:0]         lead_val;
    logic [COUNT_BITS_DEF-1:0] lead_hits;

    t_profile_result pending_results[$];

    bit idle_en = 1'b1;
    int hold_cycles = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int packets_closed = 0;
    int bursts_flagged = 0;
    int in_stall_cycles = 0;
    logic [TIME_W-1:0] t_now;

    task automatic clear_profile_model();
        foreach (byte_tally[i]) byte_tally[i] = '0;
        open_len    = '0;
        pkt_total   = '0;
        burst_total = '0;
        first_ms    = '0;
        last_ms     = '0;
        byte_total  = '0;
        lead_val    = '0;
        lead_hits   = '0;
    endtask

    task automatic profile_step(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                                input logic [TIME_W-1:0] now);
        t_profile_result r;
        logic [COUNT_BITS_DEF-1:0] c;
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] span;
        logic [65:0] prod;
        r = '0;
        case (cmd)
            CMD_DATA: begin
                c = byte_tally[b];
                if (c != HIST_MAX) c = c + 1'b1;
                byte_tally[b] = c;
                if (open_len != LEN_MAX) open_len = open_len + 1'b1;
                if (byte_total != TOTAL_MAX) byte_total = byte_total + 1'b1;
                if (c > lead_hits || (c == lead_hits && b < lead_val)) begin
                    lead_hits = c;
                    lead_val  = b;
                end
            end
            CMD_BOUND: begin
                if (open_len != 0) begin
                    r.recorded = 1'b1;
                    r.size     = OUT_SIZE_W'(open_len);
                    if (pkt_total != PCNT_MAX) pkt_total = pkt_total + 1'b1;
                    if (pkt_total == 1) begin
                        first_ms = now;
                    end else begin
                        gap  = now - last_ms;
                        span = now - first_ms;
                        prod = 66'(gap) * 66'(pkt_total - 1'b1);
                        if (span != 0 && (prod << 1) < 66'(span)) begin
                            r.burst = 1'b1;
                            if (burst_total != PCNT_MAX) burst_total = burst_total + 1'b1;
                        end
                    end
                    last_ms  = now;
                    open_len = '0;
                end
            end
            CMD_CLEAR: clear_profile_model();
            default: ;
        endcase
        r.pkt_count   = pkt_total;
        r.burst_count = burst_total;
        r.total       = byte_total;
        r.top_val     = lead_val;
        r.top_hits    = TOPC_W'(lead_hits);
        if (r.recorded) packets_closed++;
        if (r.burst) bursts_flagged++;
        pending_results.push_back(r);
    endtask

    function automatic int long_tail();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        if (r < 90) return $urandom_range(3, 8);
        return $urandom_range(15, 50);
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                             input logic [TIME_W-1:0] now);
        int gap;
        gap = (idle_en && $urandom_range(0, 2) == 0) ? long_tail() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_command   <= cmd;
        i_data_byte <= b;
        i_time_ms   <= now;
        i_in_valid  <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        profile_step(cmd, b, now);
        items_sent++;
    endtask

    // receiver: long hold when requested, otherwise random stall bursts while idle_en is set
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_cycles--;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else if (!idle_en || $urandom_range(0, 3) != 0) begin
                i_out_stall <= 1'b0;
            end else begin
                stall_left = long_tail() - 1;
                i_out_stall <= 1'b1;
            end
        end
    end

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_profile_result want;
        if (i_rst_n && i_in_valid && o_in_stall) in_stall_cycles++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, expected none, actual %0h",
                         $time, o_packet_count);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                report_field("packet_recorded", want.recorded, o_packet_recorded);
                report_field("is_burst", want.burst, o_is_burst);
                report_field("packet_size", want.size, o_packet_size);
                report_field("packet_count", want.pkt_count, o_packet_count);
                report_field("burst_count", want.burst_count, o_burst_count);
                report_field("total_bytes", want.total, o_total_bytes);
                report_field("top_byte", want.top_val, o_top_byte);
                report_field("top_count", want.top_hits, o_top_count);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("[serial_traffic_burst_profiler_top] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_directed_cases();
        send_item(CMD_CLEAR, 8'h00, 32'd0);
        send_item(CMD_DATA, 8'h00, $urandom());
        send_item(CMD_DATA, 8'hFF, $urandom());
        send_item(CMD_DATA, 8'hFF, $urandom());
        send_item(CMD_DATA, 8'h00, $urandom());
        send_item(CMD_DATA, 8'h80, $urandom());
        send_item(CMD_BOUND, 8'h00, 32'd100);
        send_item(CMD_BOUND, 8'h00, 32'd150);
        send_item(CMD_DATA, 8'h11, 32'd0);
        send_item(CMD_BOUND, 8'h00, 32'd1000);
        send_item(CMD_DATA, 8'h22, 32'd0);
        send_item(CMD_BOUND, 8'h00, 32'd1100);
        send_item(CMD_DATA, 8'h33, 32'd0);
        send_item(CMD_BOUND, 8'h00, 32'd1100);
        send_item(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF);
        send_item(CMD_CLEAR, 8'hFF, 32'hFFFF_FFFF);
        send_item(CMD_BOUND, 8'h00, 32'd0);
        send_item(CMD_DATA, 8'hFF, 32'd0);
        send_item(CMD_BOUND, 8'h00, 32'hFFFF_FFFF);
        send_item(CMD_DATA, 8'h01, 32'd0);
        send_item(CMD_BOUND, 8'h00, 32'd5);
        send_item(CMD_DATA, 8'h02, 32'd0);
        send_item(CMD_BOUND, 8'h00, 32'd3);
        send_item(CMD_DATA, 8'h03, 32'd0);
        send_item(CMD_BOUND, 8'h00, 32'hFFFF_FFFF);
    endtask

    task automatic test_output_hold();
        idle_en = 1'b0;
        hold_cycles = HOLD_CYCLES;
        repeat (20) begin
            send_item(CMD_DATA, 8'($urandom_range(0, 3)), $urandom());
            t_now = t_now + $urandom_range(0, 20);
            send_item(CMD_BOUND, 8'h00, t_now);
        end
        idle_en = 1'b1;
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 8'($urandom_range(0, 7));
        if (r < 60) return (r < 55) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [TIME_W-1:0] pick_gap_ms();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return $urandom_range(0, 12);
        if (r < 85) return $urandom_range(40, 160);
        if (r < 97) return $urandom_range(300, 3000);
        return 0;
    endfunction

    task automatic test_random_traffic();
        int r;
        int len;
        int start;
        start = items_sent;
        t_now = 32'hFFFF_FF00;
        while (items_sent - start < ITEM_BUDGET) begin
            if ($urandom_range(0, 19) == 0) idle_en = !idle_en;
            r = $urandom_range(0, 99);
            if (r < 85) begin
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 40);
                repeat (len) send_item(CMD_DATA, pick_byte(), $urandom());
                t_now = t_now + pick_gap_ms();
                send_item(CMD_BOUND, pick_byte(), t_now);
            end else if (r < 90) begin
                send_item(CMD_BOUND, pick_byte(), $urandom());
            end else if (r < 94) begin
                send_item(CMD_UNUSED, pick_byte(), $urandom());
            end else if (r < 96) begin
                send_item(CMD_CLEAR, pick_byte(), $urandom());
            end else if (r < 99) begin
                t_now = $urandom();
            end else begin
                repeat ($urandom_range(1, 3)) send_item(CMD_DATA, pick_byte(), t_now);
            end
        end
        idle_en = 1'b1;
    endtask

    initial begin
        clear_profile_model();
        t_now = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_output_hold();
        test_random_traffic();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("run: %0d transfers in, %0d results checked, %0d packets, %0d bursts",
                 items_sent, results_checked, packets_closed, bursts_flagged);
        $display("run: input stalled for %0d cycles under output back-pressure",
                 in_stall_cycles);
        if (errors == 0) begin
            $display("[serial_traffic_burst_profiler_top] OK");
        end else begin
            $display("[serial_traffic_burst_profiler_top] ERROR");
        end
        $finish;
    end

endmodule
